>>> rtl/sfd_pkg.sv
// Shared types, constants and the CRC-16 byte update for the serial deframer.
// No dependencies; every other file of the block imports this package.
package sfd_pkg;

  // Header byte codes.
  localparam logic [7:0] TYPE_DATA_BYTE     = 8'h00;
  localparam logic [7:0] TYPE_COMMAND_BYTE  = 8'h01;
  localparam logic [7:0] TYPE_RESPONSE_BYTE = 8'h81;
  localparam logic [7:0] LEN_HIGH_MAX       = 8'h05;

  // Frame type codes as reported on the result channel.
  localparam logic [1:0] FTYPE_DATA     = 2'd0;
  localparam logic [1:0] FTYPE_COMMAND  = 2'd1;
  localparam logic [1:0] FTYPE_RESPONSE = 2'd2;

  // Register reset values.
  localparam logic [7:0]  START_MARKER_RST = 8'hF0;
  localparam logic [10:0] MAX_PAYLOAD_RST  = 11'd1514;
  localparam logic [15:0] CRC_POLY_RST     = 16'hA001;
  localparam logic [15:0] CRC_SEED_RST     = 16'hFFFF;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd1;
  localparam logic [1:0] REG_CRC_POLY     = 2'd2;
  localparam logic [1:0] REG_CRC_SEED     = 2'd3;

  // Deframer phases.
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_BODY   = 3'd4,
    PH_CRC_HI = 3'd5
  } sfd_phase_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_ABORT = 2'd3
  } sfd_kind_e;

  // One received item after classification by the front end.
  typedef struct packed {
    logic       gap;
    logic [7:0] data;
    logic       is_start;
    logic       type_ok;
    logic [1:0] type_code;
    logic       len_hi_ok;
  } sfd_item_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [10:0] max_payload;
    logic [15:0] crc_poly;
    logic [15:0] crc_seed;
  } sfd_cfg_t;

  // Reflected CRC-16 update over one byte, one bit per step.
  function automatic logic [15:0] sfd_crc_byte(input logic [15:0] crc,
                                               input logic [7:0]  data,
                                               input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/sfd_queue.sv
// Front end of the deframer: classifies received items and queues them.
// Depends on sfd_pkg for the item type and header byte codes.
module sfd_queue
  import sfd_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] start_marker_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] rx_byte_i,
  output logic       head_valid_o,
  output sfd_item_t  head_o,
  input  logic       pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sfd_item_t        entry_q [Depth];
  sfd_item_t        item;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  logic             pop;

  // Classify the incoming byte against the start marker and header codes.
  always_comb begin
    item           = '0;
    item.gap       = mode_i;
    item.data      = rx_byte_i;
    item.is_start  = (rx_byte_i == start_marker_i);
    item.len_hi_ok = (rx_byte_i <= LEN_HIGH_MAX);
    case (rx_byte_i)
      TYPE_DATA_BYTE: begin
        item.type_ok   = 1'b1;
        item.type_code = FTYPE_DATA;
      end
      TYPE_COMMAND_BYTE: begin
        item.type_ok   = 1'b1;
        item.type_code = FTYPE_COMMAND;
      end
      TYPE_RESPONSE_BYTE: begin
        item.type_ok   = 1'b1;
        item.type_code = FTYPE_RESPONSE;
      end
      default: begin
        item.type_ok   = 1'b0;
        item.type_code = FTYPE_DATA;
      end
    endcase
  end

  assign in_stall_o   = (count_q == CntW'(Depth));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = entry_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

endmodule

>>> rtl/sfd_engine.sv
// Back end of the deframer: header parsing, CRC check, counters and result register.
// Depends on sfd_pkg for the phase and kind enums, item and config structs and CRC.
module sfd_engine
  import sfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sfd_cfg_t    cfg_i,
  input  logic        head_valid_i,
  input  sfd_item_t   head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  frame_kind_o,
  output logic [10:0] frame_length_o,
  output logic        end_of_frame_o,
  output logic [31:0] good_frames_o,
  output logic [31:0] crc_errors_o
);

  sfd_phase_e  phase_q, phase_d;
  logic [1:0]  type_q, type_d;
  logic [10:0] len_q, len_d;
  logic [10:0] body_q, body_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  low_q, low_d;
  logic [31:0] good_q, good_d;
  logic [31:0] err_q, err_d;

  logic        advance;
  logic        emit;
  sfd_kind_e   res_kind;
  logic [7:0]  res_byte;
  logic [15:0] crc_base;
  logic [15:0] crc_fed;
  logic [10:0] len_full;

  logic        out_valid_q;
  sfd_kind_e   out_kind_q;
  logic [7:0]  out_byte_q;
  logic [1:0]  out_type_q;
  logic [10:0] out_len_q;
  logic        out_eof_q;
  logic [31:0] out_good_q;
  logic [31:0] out_err_q;

  // Take the next queued item whenever the result register can take a result.
  assign advance = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = advance;

  // A new frame restarts the CRC from the seed; otherwise it continues.
  assign crc_base = (phase_q == PH_HUNT) ? cfg_i.crc_seed : crc_q;
  assign crc_fed  = sfd_crc_byte(crc_base, head_i.data, cfg_i.crc_poly);
  assign len_full = {len_q[10:8], head_i.data};

  // Next state, CRC, counters and the result for this item.
  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    len_d    = len_q;
    body_d   = body_q;
    crc_d    = crc_q;
    low_d    = low_q;
    good_d   = good_q;
    err_d    = err_q;
    emit     = 1'b0;
    res_kind = KIND_BYTE;
    res_byte = 8'h00;
    if (advance) begin
      if (head_i.gap) begin
        // A gap after an accepted header aborts the frame.
        if (phase_q == PH_BODY || phase_q == PH_CRC_HI) begin
          emit     = 1'b1;
          res_kind = KIND_ABORT;
        end
        phase_d = PH_HUNT;
      end else begin
        case (phase_q)
          PH_TYPE: begin
            crc_d = crc_fed;
            if (head_i.type_ok) begin
              type_d  = head_i.type_code;
              phase_d = PH_LEN_HI;
            end else begin
              phase_d = PH_HUNT;
            end
          end
          PH_LEN_HI: begin
            crc_d = crc_fed;
            if (head_i.len_hi_ok) begin
              len_d   = {head_i.data[2:0], 8'h00};
              phase_d = PH_LEN_LO;
            end else begin
              phase_d = PH_HUNT;
            end
          end
          PH_LEN_LO: begin
            crc_d = crc_fed;
            len_d = len_full;
            if (len_full <= cfg_i.max_payload) begin
              body_d  = '0;
              phase_d = PH_BODY;
            end else begin
              phase_d = PH_HUNT;
            end
          end
          PH_BODY: begin
            if (body_q < len_q) begin
              crc_d    = crc_fed;
              body_d   = body_q + 11'd1;
              emit     = 1'b1;
              res_kind = KIND_BYTE;
              res_byte = head_i.data;
            end else begin
              low_d   = head_i.data;
              phase_d = PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            phase_d = PH_HUNT;
            emit    = 1'b1;
            if ({head_i.data, low_q} == crc_q) begin
              good_d   = good_q + 32'd1;
              res_kind = KIND_GOOD;
            end else begin
              err_d    = err_q + 32'd1;
              res_kind = KIND_BAD;
            end
          end
          default: begin
            phase_d = PH_HUNT;
            if (head_i.is_start) begin
              crc_d   = crc_fed;
              phase_d = PH_TYPE;
            end
          end
        endcase
      end
    end
  end

  // Phase register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Frame context, CRC and running counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= '0;
      len_q  <= '0;
      body_q <= '0;
      crc_q  <= CRC_SEED_RST;
      low_q  <= '0;
      good_q <= '0;
      err_q  <= '0;
    end else begin
      type_q <= type_d;
      len_q  <= len_d;
      body_q <= body_d;
      crc_q  <= crc_d;
      low_q  <= low_d;
      good_q <= good_d;
      err_q  <= err_d;
    end
  end

  // Result register: holds a beat until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
      out_type_q <= type_q;
      out_len_q  <= len_q;
      out_eof_q  <= (res_kind != KIND_BYTE);
      out_good_q <= good_d;
      out_err_q  <= err_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign payload_byte_o = out_byte_q;
  assign frame_kind_o   = out_type_q;
  assign frame_length_o = out_len_q;
  assign end_of_frame_o = out_eof_q;
  assign good_frames_o  = out_good_q;
  assign crc_errors_o   = out_err_q;

  // The payload counter never runs past the header length.
  a_body_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (body_q <= len_q))
    else $error("payload count beyond frame length");

  // A gap always sends the deframer back to hunting.
  a_gap_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && head_i.gap) |=> (phase_q == PH_HUNT))
    else $error("gap did not restart the hunt");

  // The good-frame count only ever steps by one, on a good verdict.
  a_good_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (good_q != $past(good_q)) |->
      ((good_q == $past(good_q) + 32'd1) && $past(emit) && $past(res_kind == KIND_GOOD)))
    else $error("good frame count moved without a good verdict");

  // No item is taken while a stalled result is still waiting.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("result register overwritten while stalled");

  // End of frame marks exactly the verdict beats.
  a_eof_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_eof_q == (out_kind_q != KIND_BYTE)))
    else $error("end of frame flag disagrees with result kind");

endmodule

>>> rtl/serial_frame_deframer_crc_check_core.sv
// Top level of the serial frame deframer with CRC-16 check: registers and wiring.
// Depends on sfd_pkg, sfd_queue (front end) and sfd_engine (back end).
//
//   Channel   Direction  Handshake                    Beat contents
//   in        in         in_valid_i / in_stall_o      mode_i, rx_byte_i
//   out       out        out_valid_o / out_stall_i    kind_o .. crc_errors_o
//   config    in         psel, penable, pwrite        paddr, pwdata / prdata
//
// Each beat is classified on entry, queued, then parsed by the back end, so one beat
// per cycle is sustained while results do not stall; each result is registered.
// The throughput is set by the combinational byte-wide CRC update in the back end.
// The input stalls only when the queue is full, which happens while results stall.
// Reset clears the queue, the phase, the counters and the registers to their defaults.
module serial_frame_deframer_crc_check_core
  import sfd_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  frame_kind_o,
  output logic [10:0] frame_length_o,
  output logic        end_of_frame_o,
  output logic [31:0] good_frames_o,
  output logic [31:0] crc_errors_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  start_marker_q;
  logic [10:0] max_payload_q;
  logic [15:0] crc_poly_q;
  logic [15:0] crc_seed_q;
  logic        cfg_write;
  sfd_cfg_t    cfg;
  logic        head_valid;
  sfd_item_t   head;
  logic        pop;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= START_MARKER_RST;
      max_payload_q  <= MAX_PAYLOAD_RST;
      crc_poly_q     <= CRC_POLY_RST;
      crc_seed_q     <= CRC_SEED_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_START_MARKER: start_marker_q <= pwdata[7:0];
        REG_MAX_PAYLOAD:  max_payload_q  <= pwdata[10:0];
        REG_CRC_POLY:     crc_poly_q     <= pwdata[15:0];
        REG_CRC_SEED:     crc_seed_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_START_MARKER: prdata = {24'h0, start_marker_q};
      REG_MAX_PAYLOAD:  prdata = {21'h0, max_payload_q};
      REG_CRC_POLY:     prdata = {16'h0, crc_poly_q};
      REG_CRC_SEED:     prdata = {16'h0, crc_seed_q};
      default:          prdata = 32'h0;
    endcase
  end

  assign cfg.max_payload = max_payload_q;
  assign cfg.crc_poly    = crc_poly_q;
  assign cfg.crc_seed    = crc_seed_q;

  // Front end: classify and queue received beats.
  sfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_marker_i (start_marker_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .rx_byte_i      (rx_byte_i),
    .head_valid_o   (head_valid),
    .head_o         (head),
    .pop_i          (pop)
  );

  // Back end: frame parsing, CRC check and result register.
  sfd_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_kind_o   (frame_kind_o),
    .frame_length_o (frame_length_o),
    .end_of_frame_o (end_of_frame_o),
    .good_frames_o  (good_frames_o),
    .crc_errors_o   (crc_errors_o)
  );

endmodule

>>> test/tb_serial_frame_deframer_crc_check_core.sv
// Self-checking testbench for the serial frame deframer with CRC-16 check.
// Depends on sfd_pkg and serial_frame_deframer_crc_check_core; no other files.
`timescale 1ns / 100ps

module tb_serial_frame_deframer_crc_check_core;
  import sfd_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;

  // One input beat: a received byte or a gap timeout.
  typedef struct packed {
    logic       gap;
    logic [7:0] data;
  } rx_beat_t;

  // One expected result beat.
  typedef struct packed {
    sfd_kind_e   kind;
    logic [7:0]  payload;
    logic [1:0]  ftype;
    logic [10:0] flen;
    logic        eof;
    logic [31:0] good;
    logic [31:0] errs;
  } frame_result_t;

  // Ways in which a generated frame departs from a well-formed one.
  typedef enum int {
    FLAW_NONE,
    FLAW_CRC,
    FLAW_GAP,
    FLAW_TYPE,
    FLAW_LEN_HI,
    FLAW_LEN_MAX
  } frame_flaw_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [1:0]  frame_kind_o;
  logic [10:0] frame_length_o;
  logic        end_of_frame_o;
  logic [31:0] good_frames_o;
  logic [31:0] crc_errors_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  serial_frame_deframer_crc_check_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_kind_o   (frame_kind_o),
    .frame_length_o (frame_length_o),
    .end_of_frame_o (end_of_frame_o),
    .good_frames_o  (good_frames_o),
    .crc_errors_o   (crc_errors_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Register copies used by both the predictor and the frame generator.
  logic [7:0]  cfg_marker  = START_MARKER_RST;
  logic [10:0] cfg_max_len = MAX_PAYLOAD_RST;
  logic [15:0] cfg_poly    = CRC_POLY_RST;
  logic [15:0] cfg_seed    = CRC_SEED_RST;

  // Deframer state as predicted.
  sfd_phase_e  ph        = PH_HUNT;
  logic [1:0]  held_type = FTYPE_DATA;
  logic [10:0] held_len  = '0;
  logic [10:0] body_cnt  = '0;
  logic [15:0] run_crc   = CRC_SEED_RST;
  logic [7:0]  crc_lo    = '0;
  logic [31:0] good_cnt  = '0;
  logic [31:0] err_cnt   = '0;

  rx_beat_t      rx_pending[$];
  rx_beat_t      frame_buf[$];
  frame_result_t expected_results[$];

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int items_queued = 0;
  int beats_sent = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int seen_bytes = 0;
  int seen_good = 0;
  int seen_bad = 0;
  int seen_abort = 0;
  int idle_left = 0;
  int stall_left = 0;

  // Clock. The single reset at the start is released in the test sequence.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Reflected CRC-16 over one byte, data bit folded into the feedback term.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ b[k]) ? ((r >> 1) ^ cfg_poly) : (r >> 1);
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic expect_result(input sfd_kind_e kind, input logic [7:0] b, input logic eof);
    frame_result_t res;
    res.kind    = kind;
    res.payload = b;
    res.ftype   = held_type;
    res.flen    = held_len;
    res.eof     = eof;
    res.good    = good_cnt;
    res.errs    = err_cnt;
    expected_results.push_back(res);
  endtask

  // Predicts the effect of one accepted input beat.
  task automatic deframe_beat(input logic gap, input logic [7:0] b);
    if (gap) begin
      // A gap once the header is in aborts the frame; elsewhere it is silent.
      if (ph == PH_BODY || ph == PH_CRC_HI) expect_result(KIND_ABORT, 8'h00, 1'b1);
      ph = PH_HUNT;
      return;
    end
    case (ph)
      PH_TYPE: begin
        run_crc = crc_fold(run_crc, b);
        ph = PH_LEN_HI;
        if (b == TYPE_DATA_BYTE) held_type = FTYPE_DATA;
        else if (b == TYPE_COMMAND_BYTE) held_type = FTYPE_COMMAND;
        else if (b == TYPE_RESPONSE_BYTE) held_type = FTYPE_RESPONSE;
        else ph = PH_HUNT;
      end
      PH_LEN_HI: begin
        run_crc = crc_fold(run_crc, b);
        if (b <= LEN_HIGH_MAX) begin
          held_len = {b[2:0], 8'h00};
          ph = PH_LEN_LO;
        end else begin
          ph = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        run_crc = crc_fold(run_crc, b);
        held_len = held_len | {3'b000, b};
        if (held_len <= cfg_max_len) begin
          body_cnt = '0;
          ph = PH_BODY;
        end else begin
          ph = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (body_cnt < held_len) begin
          run_crc = crc_fold(run_crc, b);
          body_cnt = body_cnt + 11'd1;
          expect_result(KIND_BYTE, b, 1'b0);
        end else begin
          crc_lo = b;
          ph = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        ph = PH_HUNT;
        if ({b, crc_lo} == run_crc) begin
          good_cnt = good_cnt + 32'd1;
          expect_result(KIND_GOOD, 8'h00, 1'b1);
        end else begin
          err_cnt = err_cnt + 32'd1;
          expect_result(KIND_BAD, 8'h00, 1'b1);
        end
      end
      default: begin
        // Hunting: only the start marker opens a frame.
        ph = PH_HUNT;
        if (b == cfg_marker) begin
          run_crc = crc_fold(cfg_seed, b);
          ph = PH_TYPE;
        end
      end
    endcase
  endtask

  // Input driver: holds a stalled beat, otherwise sends the next one after its gap.
  always @(posedge clk_i or negedge rst_ni) begin
    rx_beat_t beat;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i     <= 1'b0;
      rx_byte_i  <= 8'h00;
      idle_left  = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframe_beat(mode_i, rx_byte_i);
        beats_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        // Payload stays put while stalled.
      end else if (idle_left > 0) begin
        idle_left--;
        in_valid_i <= 1'b0;
      end else if (rx_pending.size() != 0) begin
        beat = rx_pending.pop_front();
        mode_i     <= beat.gap;
        rx_byte_i  <= beat.data;
        in_valid_i <= 1'b1;
        idle_left  = pick_gap(send_idle);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor: compares each accepted beat with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        case (kind_o)
          KIND_BYTE: seen_bytes++;
          KIND_GOOD: seen_good++;
          KIND_BAD:  seen_bad++;
          default:   seen_abort++;
        endcase
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result beat: kind %0d byte %02h", kind_o, payload_byte_o);
          end
        end else begin
          res = expected_results.pop_front();
          if (kind_o !== res.kind || payload_byte_o !== res.payload ||
              frame_kind_o !== res.ftype || frame_length_o !== res.flen ||
              end_of_frame_o !== res.eof || good_frames_o !== res.good ||
              crc_errors_o !== res.errs) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected kind %0d byte %02h type %0d len %0d eof %0b good %0d err %0d",
                       res.kind, res.payload, res.ftype, res.flen, res.eof, res.good, res.errs);
              $display("          actual   kind %0d byte %02h type %0d len %0d eof %0b good %0d err %0d",
                       kind_o, payload_byte_o, frame_kind_o, frame_length_o, end_of_frame_o,
                       good_frames_o, crc_errors_o);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  = pick_gap(recv_idle);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("serial_frame_deframer_crc_check_core verification failed");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_MARKER: cfg_marker  = val[7:0];
      REG_MAX_PAYLOAD:  cfg_max_len = val[10:0];
      REG_CRC_POLY:     cfg_poly    = val[15:0];
      default:          cfg_seed    = val[15:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic cfg_all(input logic [7:0] marker, input logic [10:0] max_len,
                         input logic [15:0] poly, input logic [15:0] seed);
    cfg_write(REG_START_MARKER, {24'h0, marker});
    cfg_write(REG_MAX_PAYLOAD, {21'h0, max_len});
    cfg_write(REG_CRC_POLY, {16'h0, poly});
    cfg_write(REG_CRC_SEED, {16'h0, seed});
  endtask

  // Waits until every beat is sent and every result has come, then lets
  // the pipeline empty of beats that produce nothing.
  task automatic settle();
    while (rx_pending.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic rx_beat_t noise_beat();
    rx_beat_t beat;
    beat.gap  = ($urandom_range(0, 5) == 0);
    beat.data = 8'($urandom_range(0, 255));
    return beat;
  endfunction

  function automatic rx_beat_t byte_beat(input logic [7:0] b);
    rx_beat_t beat;
    beat.gap  = 1'b0;
    beat.data = b;
    return beat;
  endfunction

  // Builds one frame under the current registers into frame_buf.
  task automatic build_frame(input frame_flaw_e flaw, input int len);
    logic [15:0] crc;
    logic [7:0]  tbyte;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  b;
    int          n;
    int          pos;
    frame_buf.delete();
    case ($urandom_range(0, 2))
      0:       tbyte = TYPE_DATA_BYTE;
      1:       tbyte = TYPE_COMMAND_BYTE;
      default: tbyte = TYPE_RESPONSE_BYTE;
    endcase
    hi = len[15:8];
    lo = len[7:0];
    if (flaw == FLAW_TYPE) begin
      do tbyte = 8'($urandom_range(0, 255));
      while (tbyte == TYPE_DATA_BYTE || tbyte == TYPE_COMMAND_BYTE ||
             tbyte == TYPE_RESPONSE_BYTE);
    end
    if (flaw == FLAW_LEN_HI) hi = 8'($urandom_range(LEN_HIGH_MAX + 1, 255));
    n = (flaw == FLAW_TYPE || flaw == FLAW_LEN_HI || flaw == FLAW_LEN_MAX) ? 3 : len;
    frame_buf.push_back(byte_beat(cfg_marker));
    frame_buf.push_back(byte_beat(tbyte));
    frame_buf.push_back(byte_beat(hi));
    frame_buf.push_back(byte_beat(lo));
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom_range(0, 255));
      frame_buf.push_back(byte_beat(b));
    end
    crc = cfg_seed;
    foreach (frame_buf[k]) crc = crc_fold(crc, frame_buf[k].data);
    frame_buf.push_back(byte_beat(crc[7:0]));
    frame_buf.push_back(byte_beat(crc[15:8]));
    if (flaw == FLAW_CRC) begin
      pos = frame_buf.size() - 1 - $urandom_range(0, 1);
      frame_buf[pos].data[$urandom_range(0, 7)] ^= 1'b1;
    end
    if (flaw == FLAW_GAP) begin
      // Cut anywhere from just after the marker to just before the last byte.
      pos = $urandom_range(1, frame_buf.size() - 1);
      frame_buf = frame_buf[0:pos-1];
      frame_buf.push_back(noise_beat() | rx_beat_t'({1'b1, 8'h00}));
    end
  endtask

  task automatic send_buf();
    foreach (frame_buf[k]) rx_pending.push_back(frame_buf[k]);
    items_queued += frame_buf.size();
  endtask

  // Random traffic: mostly well-formed frames, the rest damaged frames and noise.
  task automatic run_random(input int n);
    int start;
    int r;
    int len;
    int cap;
    int top;
    start = items_queued;
    while (items_queued - start < n) begin
      r   = $urandom_range(0, 99);
      cap = (cfg_max_len < 40) ? int'(cfg_max_len) : 40;
      len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, (cap < 6) ? cap : 6)
                                         : $urandom_range(0, cap);
      if (r < 60) begin
        build_frame(FLAW_NONE, len);
      end else if (r < 70) begin
        build_frame(FLAW_CRC, len);
      end else if (r < 78) begin
        build_frame(FLAW_GAP, len);
      end else if (r < 84) begin
        build_frame(FLAW_TYPE, len);
      end else if (r < 88) begin
        build_frame(FLAW_LEN_HI, len);
      end else if (r < 92) begin
        if (cfg_max_len < 11'd1535) begin
          top = int'(cfg_max_len) + 16;
          if (top > 1535) top = 1535;
          build_frame(FLAW_LEN_MAX, $urandom_range(int'(cfg_max_len) + 1, top));
        end else begin
          build_frame(FLAW_LEN_HI, len);
        end
      end else begin
        frame_buf.delete();
        repeat ($urandom_range(1, 4)) frame_buf.push_back(noise_beat());
      end
      send_buf();
    end
  endtask

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset registers: directed cases first.
    frame_buf.delete();
    frame_buf.push_back(rx_beat_t'({1'b1, 8'hFF}));        // gap while hunting
    send_buf();
    build_frame(FLAW_NONE, 0);                             // zero-length frame
    send_buf();
    build_frame(FLAW_CRC, 1);                              // CRC mismatch
    send_buf();
    build_frame(FLAW_TYPE, 0);                             // rejected type byte
    send_buf();
    frame_buf.delete();                                    // gap inside the header
    frame_buf.push_back(byte_beat(cfg_marker));
    frame_buf.push_back(byte_beat(TYPE_COMMAND_BYTE));
    frame_buf.push_back(rx_beat_t'({1'b1, 8'h00}));
    send_buf();
    frame_buf.delete();                                    // gap in mid-payload
    frame_buf.push_back(byte_beat(cfg_marker));
    frame_buf.push_back(byte_beat(TYPE_RESPONSE_BYTE));
    frame_buf.push_back(byte_beat(8'h00));
    frame_buf.push_back(byte_beat(8'h02));
    frame_buf.push_back(byte_beat(8'hFF));
    frame_buf.push_back(rx_beat_t'({1'b1, 8'h5A}));
    send_buf();
    build_frame(FLAW_LEN_MAX, 1515);                       // one over the default limit
    send_buf();
    settle();
    run_random(80);
    settle();

    // Marker equal to a type code, small limit, receiver never stalls.
    cfg_all(8'h00, 11'd20, 16'h8408, 16'h0000);
    recv_idle = 1'b0;
    run_random(60);
    settle();

    // Limit of zero and all-ones registers, sender never idles.
    cfg_all(8'hFF, 11'd0, 16'hFFFF, 16'hFFFF);
    send_idle = 1'b0;
    recv_idle = 1'b1;
    run_random(40);
    settle();

    // Largest limit: a frame with a non-zero high length byte, a length just
    // past the limit and a register change while a frame is in its payload.
    cfg_all(8'hF0, 11'd1535, 16'h0000, 16'h1D0F);
    send_idle = 1'b1;
    build_frame(FLAW_NONE, 260);
    send_buf();
    build_frame(FLAW_LEN_MAX, 1536);
    send_buf();
    settle();
    cfg_write(REG_CRC_POLY, 32'h0000_A001);
    build_frame(FLAW_NONE, 10);
    for (int k = 0; k < 8; k++) rx_pending.push_back(frame_buf[k]);
    items_queued += 8;
    settle();
    cfg_write(REG_CRC_POLY, $urandom_range(0, 65535));
    cfg_write(REG_CRC_SEED, $urandom_range(0, 65535));
    for (int k = 8; k < frame_buf.size(); k++) rx_pending.push_back(frame_buf[k]);
    items_queued += frame_buf.size() - 8;
    run_random(60);
    settle();

    // Random registers.
    cfg_all(8'($urandom_range(0, 255)), 11'($urandom_range(8, 60)),
            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    run_random(80);
    settle();

    $display("Sent %0d beats under five register settings; checked %0d payload bytes,",
             beats_sent, seen_bytes);
    $display("%0d good, %0d bad and %0d aborted frames; %0d mismatches.",
             seen_good, seen_bad, seen_abort, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("serial_frame_deframer_crc_check_core verification clean");
    end else begin
      $display("serial_frame_deframer_crc_check_core verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sfd_pkg.sv
rtl/sfd_queue.sv
rtl/sfd_engine.sv
rtl/serial_frame_deframer_crc_check_core.sv
test/tb_serial_frame_deframer_crc_check_core.sv
